// File: rtl/suk_pkg.sv
// Shared types, constants and helpers for the sorted unique key table.
package suk_pkg;

  localparam int Depth = 32;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int KeyW  = 14;
  localparam int PayW  = 31;
  localparam int StatW = 3;
  localparam int PosW  = 5;

  localparam logic [KeyW-1:0] KeyMax  = KeyW'(9999);
  localparam logic [KeyW-1:0] KeyNone = '0;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqList   = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_BADKEY    = 3'd3,
    ST_LISTED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic            ins;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
  } cell_ctrl_t;

  function automatic logic [IdxW-1:0] onehot_idx(input logic [Depth-1:0] vec);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (vec[i]) begin
        idx = idx | IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/suk_cell.sv
// One table slot: compares against the request key and shifts up on insert.
module suk_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  suk_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    left_lt_i,
  input  logic [suk_pkg::KeyW-1:0] left_key_i,
  input  logic [suk_pkg::PayW-1:0] left_pay_i,
  output logic [suk_pkg::KeyW-1:0] key_o,
  output logic [suk_pkg::PayW-1:0] pay_o,
  output logic                    lt_o,
  output logic                    eq_o
);

  logic [suk_pkg::KeyW-1:0] key_q, key_d;
  logic [suk_pkg::PayW-1:0] pay_q, pay_d;
  logic                     upd;

  assign lt_o = (key_q != suk_pkg::KeyNone) && (key_q < ctrl_i.key);
  assign eq_o = (key_q != suk_pkg::KeyNone) && (key_q == ctrl_i.key);
  assign upd  = ctrl_i.ins && !lt_o;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (upd) begin
      if (left_lt_i) begin
        key_d = ctrl_i.key;
        pay_d = ctrl_i.pay;
      end else begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= suk_pkg::KeyNone;
    end else begin
      key_q <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

// File: rtl/sorted_unique_key_table.sv
// Top level: request register, cell chain, list sequencer and result register.
// Insert: accepted into the request register, then checked and placed in the execute state.
// List of N entries: accepted, started in the execute state, then one entry per cycle while the output is not stalled.
// Results are held in the result register; stall holds them.
// Reset clears all keys, the entry count, the sequencer and the result valid.
// Stored payload words are not reset; only written slots are ever read.
module sorted_unique_key_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [suk_pkg::KeyW-1:0]   key_i,
  input  logic [suk_pkg::PayW-1:0]   payload_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [suk_pkg::StatW-1:0]  status_o,
  output logic [suk_pkg::KeyW-1:0]   entry_key_o,
  output logic [suk_pkg::PayW-1:0]   entry_payload_o,
  output logic [suk_pkg::PosW-1:0]   position_o,
  output logic                       last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                     req_type_q;
  logic [suk_pkg::KeyW-1:0] req_key_q;
  logic [suk_pkg::PayW-1:0] req_pay_q;

  logic [suk_pkg::CntW-1:0] count_q, count_d;
  logic [suk_pkg::IdxW-1:0] list_idx_q, list_idx_d;

  logic                      out_valid_q, out_valid_d;
  suk_pkg::status_e          status_q, status_d;
  logic [suk_pkg::KeyW-1:0]  okey_q, okey_d;
  logic [suk_pkg::PayW-1:0]  opay_q, opay_d;
  logic [suk_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      last_q, last_d;

  logic [suk_pkg::Depth-1:0][suk_pkg::KeyW-1:0] cell_key;
  logic [suk_pkg::Depth-1:0][suk_pkg::PayW-1:0] cell_pay;
  logic [suk_pkg::Depth-1:0]                    cell_lt;
  logic [suk_pkg::Depth-1:0]                    cell_eq;
  logic [suk_pkg::Depth-1:0]                    boundary;
  suk_pkg::cell_ctrl_t                          ctrl;

  logic accept, out_free, emit, bad_key, dup, full, do_ins, list_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign bad_key = (req_key_q == suk_pkg::KeyNone) || (req_key_q > suk_pkg::KeyMax);
  assign dup     = |cell_eq;
  assign full    = (count_q == suk_pkg::CntW'(suk_pkg::Depth));
  assign do_ins  = (state_q == S_EXEC) && out_free && (req_type_q == suk_pkg::ReqInsert)
                   && !bad_key && !dup && !full;

  assign ctrl.ins = do_ins;
  assign ctrl.key = req_key_q;
  assign ctrl.pay = req_pay_q;

  for (genvar g = 0; g < suk_pkg::Depth; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign boundary[g] = !cell_lt[g];
      suk_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .left_lt_i  (1'b1),
        .left_key_i (suk_pkg::KeyNone),
        .left_pay_i ('0),
        .key_o      (cell_key[g]),
        .pay_o      (cell_pay[g]),
        .lt_o       (cell_lt[g]),
        .eq_o       (cell_eq[g])
      );
    end else begin : g_body
      assign boundary[g] = !cell_lt[g] && cell_lt[g-1];
      suk_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .left_lt_i  (cell_lt[g-1]),
        .left_key_i (cell_key[g-1]),
        .left_pay_i (cell_pay[g-1]),
        .key_o      (cell_key[g]),
        .pay_o      (cell_pay[g]),
        .lt_o       (cell_lt[g]),
        .eq_o       (cell_eq[g])
      );
    end
  end

  assign list_last = ((suk_pkg::CntW'(list_idx_q) + suk_pkg::CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    list_idx_d  = list_idx_q;
    emit        = 1'b0;
    status_d    = status_q;
    okey_d      = okey_q;
    opay_d      = opay_q;
    pos_d       = pos_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit   = 1'b1;
          okey_d = req_key_q;
          opay_d = '0;
          pos_d  = '0;
          last_d = 1'b1;
          if (req_type_q == suk_pkg::ReqList) begin
            if (count_q == '0) begin
              status_d = suk_pkg::ST_EMPTY;
              okey_d   = suk_pkg::KeyNone;
              state_d  = S_IDLE;
            end else begin
              emit       = 1'b0;
              list_idx_d = '0;
              state_d    = S_LIST;
            end
          end else begin
            state_d = S_IDLE;
            if (bad_key) begin
              status_d = suk_pkg::ST_BADKEY;
              okey_d   = suk_pkg::KeyNone;
            end else if (dup) begin
              status_d = suk_pkg::ST_DUPLICATE;
              pos_d    = suk_pkg::PosW'(suk_pkg::onehot_idx(cell_eq));
            end else if (full) begin
              status_d = suk_pkg::ST_FULL;
            end else begin
              status_d = suk_pkg::ST_INSERTED;
              pos_d    = suk_pkg::PosW'(suk_pkg::onehot_idx(boundary));
              count_d  = count_q + suk_pkg::CntW'(1);
            end
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          emit       = 1'b1;
          status_d   = suk_pkg::ST_LISTED;
          okey_d     = cell_key[list_idx_q];
          opay_d     = cell_pay[list_idx_q];
          pos_d      = suk_pkg::PosW'(list_idx_q);
          last_d     = list_last;
          list_idx_d = list_idx_q + suk_pkg::IdxW'(1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      req_key_q  <= key_i;
      req_pay_q  <= payload_i;
    end
    status_q <= status_d;
    okey_q   <= okey_d;
    opay_q   <= opay_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign entry_key_o     = okey_q;
  assign entry_payload_o = opay_q;
  assign position_o      = pos_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= suk_pkg::CntW'(suk_pkg::Depth))
    else $error("entry count exceeds table depth");

  a_keys_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(cell_eq))
    else $error("key matches more than one slot");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (count_q != '0))
    else $error("list sequencer running on empty table");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> (count_q == $past(count_q) + suk_pkg::CntW'(1)))
    else $error("entry count did not advance on insert");
`endif

endmodule
